[sv/rrtt_pkg.sv]
// Shared types and constants of the round-robin task table.
// No dependencies; imported by rrtt_ctrl, the top level and the testbench.
`default_nettype none

package rrtt_pkg;

    localparam int DATA_W = 64;
    localparam int ID_W   = 16;
    localparam int OP_W   = 3;
    localparam int STAT_W = 3;

    localparam logic [DATA_W-1:0] TLS_VIRT_BASE  = 64'h0000_0600_0000_0000;
    localparam logic [ID_W-1:0]   KERNEL_TASK_ID = 16'd1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INIT      = 3'd0;
    localparam logic [OP_W-1:0] OP_CREATE    = 3'd1;
    localparam logic [OP_W-1:0] OP_SCHEDULE  = 3'd2;
    localparam logic [OP_W-1:0] OP_TERMINATE = 3'd3;
    localparam logic [OP_W-1:0] OP_KILL_CUR  = 3'd4;
    localparam logic [OP_W-1:0] OP_KILL_ALL  = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_REFUSED  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOINIT   = 3'd4;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK,
        S_READ,
        S_DONE
    } state_t;

    // Which slot data the result carries
    typedef enum logic [1:0] {
        RM_PLAIN,
        RM_SCHED,
        RM_ECHO,
        RM_RELEASE
    } res_mode_t;

    // Write enables of the slot memories
    typedef struct packed {
        logic sp_we;
        logic ctx_we;
    } ram_we_t;

    // One result item
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] next_stack_pointer;
        logic [DATA_W-1:0] next_root;
        logic [DATA_W-1:0] next_kernel_stack;
        logic [DATA_W-1:0] tls_base;
        logic              tls_write;
        logic [ID_W-1:0]   assigned_id;
        logic [ID_W-1:0]   current_id;
        logic              release_valid;
        logic [DATA_W-1:0] release_root;
    } res_t;

endpackage

`default_nettype wire

[sv/rrtt_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module rrtt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[sv/rrtt_ctrl.sv]
// Sequencer of the task table: input capture, table state, running flags,
// the ring-walk step unit and result assembly. Uses rrtt_pkg.
`default_nettype none

module rrtt_ctrl
    import rrtt_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [OP_W-1:0]              opcode,
    input  wire logic [DATA_W-1:0]            stack_pointer,
    input  wire logic [DATA_W-1:0]            address_root,
    input  wire logic [DATA_W-1:0]            kernel_stack_top,
    input  wire logic [ID_W-1:0]              target_id,
    input  wire logic [DATA_W-1:0]            kernel_root,
    output ram_we_t                           ram_we,
    output logic [$clog2(MAX_TASKS)-1:0]      ram_waddr,
    output logic [DATA_W-1:0]                 ram_wsp,
    output logic [DATA_W-1:0]                 ram_wroot,
    output logic [DATA_W-1:0]                 ram_wkstack,
    output logic [$clog2(MAX_TASKS)-1:0]      ram_raddr,
    input  wire logic [DATA_W-1:0]            rd_sp,
    input  wire logic [DATA_W-1:0]            rd_root,
    input  wire logic [DATA_W-1:0]            rd_kstack,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output res_t                              result
);

    localparam int SW = $clog2(MAX_TASKS);
    localparam int UW = $clog2(MAX_TASKS + 1);
    localparam logic [SW-1:0] LAST_STEP = SW'(MAX_TASKS - 1);
    localparam logic [UW-1:0] FULL_COUNT = UW'(MAX_TASKS);

    state_t state_reg, state_next;
    res_mode_t mode_reg, mode_next;
    logic [SW-1:0] cur_reg, cur_next;
    logic [UW-1:0] used_reg, used_next;
    logic init_reg, init_next;
    logic [MAX_TASKS-1:0] running_reg, running_next;
    logic [SW-1:0] walk_reg, walk_next;
    logic [SW-1:0] count_reg, count_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [ID_W-1:0] assigned_reg, assigned_next;

    logic [OP_W-1:0] op_reg;
    logic [DATA_W-1:0] sp_reg;
    logic [DATA_W-1:0] root_reg;
    logic [DATA_W-1:0] kst_reg;
    logic [ID_W-1:0] tgt_reg;

    logic [SW-1:0] step_slot;
    logic [SW-1:0] tgt_slot;
    logic tgt_in_table;

    // Capture the input item on transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= opcode;
            sp_reg   <= stack_pointer;
            root_reg <= address_root;
            kst_reg  <= kernel_stack_top;
            tgt_reg  <= target_id;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mode_reg     <= RM_PLAIN;
            cur_reg      <= '0;
            used_reg     <= '0;
            init_reg     <= 1'b0;
            running_reg  <= '0;
            walk_reg     <= '0;
            count_reg    <= '0;
            status_reg   <= STAT_OK;
            assigned_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            cur_reg      <= cur_next;
            used_reg     <= used_next;
            init_reg     <= init_next;
            running_reg  <= running_next;
            walk_reg     <= walk_next;
            count_reg    <= count_next;
            status_reg   <= status_next;
            assigned_reg <= assigned_next;
        end
    end

    // Ring successor: slot 0 links to the newest slot, every other slot to
    // the one below it
    assign step_slot = (walk_reg == '0) ? SW'(used_reg - UW'(1)) : walk_reg - SW'(1);

    // Task ids equal slot number plus one, so a lookup by id is a range check
    assign tgt_slot     = SW'(tgt_reg - ID_W'(1));
    assign tgt_in_table = (tgt_reg >= ID_W'(2)) && (tgt_reg <= ID_W'(used_reg));

    // Slot data is always read at the current slot
    assign ram_raddr = cur_reg;

    // Next state and outputs
    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        cur_next      = cur_reg;
        used_next     = used_reg;
        init_next     = init_reg;
        running_next  = running_reg;
        walk_next     = walk_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        assigned_next = assigned_reg;
        ram_we        = '0;
        ram_waddr     = cur_reg;
        ram_wsp       = sp_reg;
        ram_wroot     = root_reg;
        ram_wkstack   = kst_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                status_next   = STAT_OK;
                assigned_next = '0;
                mode_next     = RM_PLAIN;
                state_next    = S_DONE;
                case (op_reg)
                    OP_INIT:
                    begin
                        // Restart the table with the kernel task in slot 0
                        running_next    = '0;
                        running_next[0] = 1'b1;
                        ram_we.sp_we    = 1'b1;
                        ram_we.ctx_we   = 1'b1;
                        ram_waddr       = '0;
                        ram_wsp         = '0;
                        ram_wroot       = kernel_root;
                        cur_next        = '0;
                        used_next       = UW'(1);
                        init_next       = 1'b1;
                        assigned_next   = KERNEL_TASK_ID;
                    end

                    OP_CREATE:
                    begin
                        if (!init_reg)
                        begin
                            status_next = STAT_NOINIT;
                        end
                        else if (used_reg == FULL_COUNT)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            // Fill the next free slot; it links in after the head
                            ram_we.sp_we                  = 1'b1;
                            ram_we.ctx_we                 = 1'b1;
                            ram_waddr                     = used_reg[SW-1:0];
                            running_next[used_reg[SW-1:0]] = 1'b1;
                            used_next                     = used_reg + UW'(1);
                            assigned_next                 = ID_W'(used_reg) + ID_W'(1);
                        end
                    end

                    OP_SCHEDULE:
                    begin
                        if (!init_reg)
                        begin
                            status_next = STAT_NOINIT;
                            mode_next   = RM_ECHO;
                        end
                        else
                        begin
                            // Save the outgoing pointer, then walk the ring
                            ram_we.sp_we = 1'b1;
                            walk_next    = cur_reg;
                            count_next   = '0;
                            mode_next    = RM_SCHED;
                            state_next   = S_WALK;
                        end
                    end

                    OP_TERMINATE:
                    begin
                        if (tgt_reg == KERNEL_TASK_ID)
                        begin
                            status_next = STAT_REFUSED;
                        end
                        else if (!init_reg)
                        begin
                            status_next = STAT_NOINIT;
                        end
                        else if (tgt_in_table)
                        begin
                            running_next[tgt_slot] = 1'b0;
                        end
                        else
                        begin
                            status_next = STAT_NOTFOUND;
                        end
                    end

                    OP_KILL_CUR:
                    begin
                        if (!init_reg)
                        begin
                            status_next = STAT_NOINIT;
                        end
                        else if (cur_reg == '0)
                        begin
                            status_next = STAT_REFUSED;
                        end
                        else
                        begin
                            // Drop the current task and fetch its root
                            running_next[cur_reg] = 1'b0;
                            mode_next             = RM_RELEASE;
                            state_next            = S_READ;
                        end
                    end

                    OP_KILL_ALL:
                    begin
                        if (!init_reg)
                        begin
                            status_next = STAT_NOINIT;
                        end
                        else
                        begin
                            // Keep only the kernel task
                            running_next    = '0;
                            running_next[0] = running_reg[0];
                        end
                    end

                    default:
                    begin
                    end
                endcase
            end

            S_WALK:
            begin
                // Advance one link per cycle until a running slot turns up
                if (running_reg[step_slot])
                begin
                    cur_next   = step_slot;
                    state_next = S_READ;
                end
                else if (count_reg == LAST_STEP)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    walk_next  = step_slot;
                    count_next = count_reg + SW'(1);
                end
            end

            S_READ:
            begin
                state_next = S_DONE;
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Assemble the result from the slot data at the current slot
    always_comb
    begin
        result             = '0;
        result.status      = status_reg;
        result.assigned_id = assigned_reg;
        result.current_id  = init_reg ? (ID_W'(cur_reg) + ID_W'(1)) : '0;
        case (mode_reg)
            RM_SCHED:
            begin
                result.next_stack_pointer = rd_sp;
                result.next_root          = (rd_root == '0) ? kernel_root : rd_root;
                result.next_kernel_stack  = rd_kstack;
                if ((cur_reg != '0) && (rd_root != '0))
                begin
                    result.tls_base  = TLS_VIRT_BASE;
                    result.tls_write = 1'b1;
                end
            end

            RM_ECHO:
            begin
                result.next_stack_pointer = sp_reg;
            end

            RM_RELEASE:
            begin
                if ((rd_root != '0) && (rd_root != kernel_root))
                begin
                    result.release_valid = 1'b1;
                    result.release_root  = rd_root;
                end
            end

            default:
            begin
            end
        endcase
    end

    // The kernel task can never be stopped once the table is set up
    a_kernel_running: assert property (@(posedge clk) disable iff (!rst_n)
        init_reg |-> running_reg[0])
        else $error("kernel task slot lost its running flag");

    // The current slot always lies inside the filled part of the table
    a_cur_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        init_reg |-> (UW'(cur_reg) < used_reg))
        else $error("current slot beyond the filled slots");

    // The ring is walked only on a set-up table
    a_walk_init: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (init_reg && (used_reg != '0)))
        else $error("ring walk without an initialized table");

    // A result handed over returns the sequencer to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after result transfer");

endmodule

`default_nettype wire

[sv/round_robin_task_table_unit.sv]
// Top level of the round-robin task table: configuration register, slot
// memories (rrtt_ram), sequencer (rrtt_ctrl) and output register. Uses rrtt_pkg.
`default_nettype none

// One operation is in flight at a time; in_ready is high only while the
// sequencer is idle, and it rises again as soon as the result has moved into
// the output register, even while that result still waits for out_ready.
// From the input transfer the sequencer passes dispatch and then done for
// init, create, terminate, kill-all and unknown codes; kill-current adds a
// read state for one slot memory read, and schedule walks the ring, visiting
// one slot per cycle until it meets a running task, and then reads. A new item
// is taken only after the result of the last one has left the sequencer.
// There is no clearing pass after reset; kernel_root may be written
// through cfg_we/cfg_wdata while idle.
module round_robin_task_table_unit
    import rrtt_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [DATA_W-1:0] cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [OP_W-1:0]   opcode,
    input  wire logic [DATA_W-1:0] stack_pointer,
    input  wire logic [DATA_W-1:0] address_root,
    input  wire logic [DATA_W-1:0] kernel_stack_top,
    input  wire logic [ID_W-1:0]   target_id,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [STAT_W-1:0]      status,
    output logic [DATA_W-1:0]      next_stack_pointer,
    output logic [DATA_W-1:0]      next_root,
    output logic [DATA_W-1:0]      next_kernel_stack,
    output logic [DATA_W-1:0]      tls_base,
    output logic                   tls_write,
    output logic [ID_W-1:0]        assigned_id,
    output logic [ID_W-1:0]        current_id,
    output logic                   release_valid,
    output logic [DATA_W-1:0]      release_root
);

    localparam int SW = $clog2(MAX_TASKS);

    logic [DATA_W-1:0] kernel_root_reg;
    logic out_valid_reg;
    res_t out_reg;

    ram_we_t ram_we;
    logic [SW-1:0] ram_waddr;
    logic [SW-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_wsp;
    logic [DATA_W-1:0] ram_wroot;
    logic [DATA_W-1:0] ram_wkstack;
    logic [DATA_W-1:0] rd_sp;
    logic [DATA_W-1:0] rd_root;
    logic [DATA_W-1:0] rd_kstack;
    logic res_valid;
    logic res_ready;
    res_t result;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_root_reg <= '0;
        end
        else if (cfg_we)
        begin
            kernel_root_reg <= cfg_wdata;
        end
    end

    // Slot memories: saved stack pointer, address-space root, kernel stack
    rrtt_ram #(.WIDTH(DATA_W), .DEPTH(MAX_TASKS)) u_sp_ram (
        .clk   (clk),
        .we    (ram_we.sp_we),
        .waddr (ram_waddr),
        .wdata (ram_wsp),
        .raddr (ram_raddr),
        .rdata (rd_sp)
    );

    rrtt_ram #(.WIDTH(DATA_W), .DEPTH(MAX_TASKS)) u_root_ram (
        .clk   (clk),
        .we    (ram_we.ctx_we),
        .waddr (ram_waddr),
        .wdata (ram_wroot),
        .raddr (ram_raddr),
        .rdata (rd_root)
    );

    rrtt_ram #(.WIDTH(DATA_W), .DEPTH(MAX_TASKS)) u_kstack_ram (
        .clk   (clk),
        .we    (ram_we.ctx_we),
        .waddr (ram_waddr),
        .wdata (ram_wkstack),
        .raddr (ram_raddr),
        .rdata (rd_kstack)
    );

    rrtt_ctrl #(.MAX_TASKS(MAX_TASKS)) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .opcode           (opcode),
        .stack_pointer    (stack_pointer),
        .address_root     (address_root),
        .kernel_stack_top (kernel_stack_top),
        .target_id        (target_id),
        .kernel_root      (kernel_root_reg),
        .ram_we           (ram_we),
        .ram_waddr        (ram_waddr),
        .ram_wsp          (ram_wsp),
        .ram_wroot        (ram_wroot),
        .ram_wkstack      (ram_wkstack),
        .ram_raddr        (ram_raddr),
        .rd_sp            (rd_sp),
        .rd_root          (rd_root),
        .rd_kstack        (rd_kstack),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .result           (result)
    );

    // Take a result whenever the output register is empty or being drained
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    // Hold the result payload until its transfer
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= result;
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = out_reg.status;
    assign next_stack_pointer = out_reg.next_stack_pointer;
    assign next_root          = out_reg.next_root;
    assign next_kernel_stack  = out_reg.next_kernel_stack;
    assign tls_base           = out_reg.tls_base;
    assign tls_write          = out_reg.tls_write;
    assign assigned_id        = out_reg.assigned_id;
    assign current_id         = out_reg.current_id;
    assign release_valid      = out_reg.release_valid;
    assign release_root       = out_reg.release_root;

endmodule

`default_nettype wire

[tb/task_table_check_pkg.sv]
// Scoreboard for the round-robin task table: a cycle-free model of the slot ring
// and a queue of awaited replies. Depends on rrtt_pkg for codes, widths and res_t.
package task_table_check_pkg;

    import rrtt_pkg::*;

    localparam int SLOTS = 16;

    // Codes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    // One request as presented on the input channel
    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [DATA_W-1:0] stack_pointer;
        logic [DATA_W-1:0] address_root;
        logic [DATA_W-1:0] kernel_stack_top;
        logic [ID_W-1:0]   target_id;
    } request_t;

    class task_table_scoreboard;

        // Slot ring as the block should hold it
        logic [ID_W-1:0]   slot_id     [SLOTS];
        bit                slot_live   [SLOTS];
        logic [3:0]        slot_next   [SLOTS];
        logic [DATA_W-1:0] slot_sp     [SLOTS];
        logic [DATA_W-1:0] slot_root   [SLOTS];
        logic [DATA_W-1:0] slot_kstack [SLOTS];
        logic [DATA_W-1:0] slot_tls    [SLOTS];
        logic [3:0]        cur_slot;
        int                used_slots;
        logic [ID_W-1:0]   next_id;
        bit                booted;
        logic [DATA_W-1:0] kroot;

        res_t awaited_replies[$];

        int mismatches;
        int replies_checked;
        int releases;
        int op_count[8];
        int status_count[8];

        function new();
            foreach (slot_id[k])
            begin
                slot_id[k]     = '0;
                slot_live[k]   = 1'b0;
                slot_next[k]   = '0;
                slot_sp[k]     = '0;
                slot_root[k]   = '0;
                slot_kstack[k] = '0;
                slot_tls[k]    = '0;
            end
            cur_slot        = '0;
            used_slots      = 0;
            next_id         = 16'd1;
            booted          = 1'b0;
            kroot           = '0;
            mismatches      = 0;
            replies_checked = 0;
            releases        = 0;
            foreach (op_count[k])
            begin
                op_count[k]     = 0;
                status_count[k] = 0;
            end
        endfunction

        function void set_kernel_root(logic [DATA_W-1:0] value);
            kroot = value;
        endfunction

        function int pending();
            return awaited_replies.size();
        endfunction

        // Apply one request to the ring and return the reply it must produce
        function res_t advance_table(request_t rq);
            res_t       r;
            logic [3:0] cur;
            logic [3:0] s;
            int         i;
            r   = '0;
            cur = cur_slot;
            case (rq.opcode)
                OP_INIT:
                begin
                    foreach (slot_live[k])
                        slot_live[k] = 1'b0;
                    slot_id[0]     = KERNEL_TASK_ID;
                    next_id        = KERNEL_TASK_ID + 16'd1;
                    slot_live[0]   = 1'b1;
                    slot_root[0]   = kroot;
                    slot_kstack[0] = rq.kernel_stack_top;
                    slot_sp[0]     = '0;
                    slot_tls[0]    = '0;
                    slot_next[0]   = '0;
                    cur_slot       = '0;
                    cur            = '0;
                    used_slots     = 1;
                    booted         = 1'b1;
                    r.assigned_id  = KERNEL_TASK_ID;
                end
                OP_CREATE:
                begin
                    if (!booted)
                        r.status = STAT_NOINIT;
                    else if (used_slots >= SLOTS)
                        r.status = STAT_FULL;
                    else
                    begin
                        s              = used_slots[3:0];
                        slot_id[s]     = next_id;
                        next_id        = next_id + 16'd1;
                        slot_live[s]   = 1'b1;
                        slot_root[s]   = rq.address_root;
                        slot_kstack[s] = rq.kernel_stack_top;
                        slot_sp[s]     = rq.stack_pointer;
                        slot_tls[s]    = (rq.address_root != '0) ? TLS_VIRT_BASE : '0;
                        // Link in right after the head
                        slot_next[s]   = slot_next[0];
                        slot_next[0]   = s;
                        used_slots++;
                        r.assigned_id  = slot_id[s];
                    end
                end
                OP_SCHEDULE:
                begin
                    if (!booted)
                    begin
                        r.status             = STAT_NOINIT;
                        r.next_stack_pointer = rq.stack_pointer;
                    end
                    else
                    begin
                        slot_sp[cur] = rq.stack_pointer;
                        // Walk at most one lap to the next running slot
                        s = cur;
                        for (i = 0; i < SLOTS; i++)
                        begin
                            s = slot_next[s];
                            if (slot_live[s])
                            begin
                                cur = s;
                                break;
                            end
                        end
                        cur_slot             = cur;
                        r.next_stack_pointer = slot_sp[cur];
                        r.next_root          = (slot_root[cur] == '0) ? kroot : slot_root[cur];
                        r.next_kernel_stack  = slot_kstack[cur];
                        r.tls_base           = slot_tls[cur];
                        r.tls_write          = (slot_tls[cur] != '0);
                    end
                end
                OP_TERMINATE:
                begin
                    if (rq.target_id == KERNEL_TASK_ID)
                        r.status = STAT_REFUSED;
                    else if (!booted)
                        r.status = STAT_NOINIT;
                    else
                    begin
                        // Search from the head; a dead slot still matches
                        r.status = STAT_NOTFOUND;
                        s = '0;
                        for (i = 0; i < used_slots; i++)
                        begin
                            if (slot_id[s] == rq.target_id)
                            begin
                                slot_live[s] = 1'b0;
                                r.status     = STAT_OK;
                                break;
                            end
                            s = slot_next[s];
                        end
                    end
                end
                OP_KILL_CUR:
                begin
                    if (!booted)
                        r.status = STAT_NOINIT;
                    else if (slot_id[cur] == KERNEL_TASK_ID)
                        r.status = STAT_REFUSED;
                    else
                    begin
                        if (slot_root[cur] != '0 && slot_root[cur] != kroot)
                        begin
                            r.release_valid = 1'b1;
                            r.release_root  = slot_root[cur];
                        end
                        slot_live[cur] = 1'b0;
                    end
                end
                OP_KILL_ALL:
                begin
                    if (!booted)
                        r.status = STAT_NOINIT;
                    else
                        for (i = 0; i < used_slots; i++)
                            if (slot_id[i] != KERNEL_TASK_ID)
                                slot_live[i] = 1'b0;
                end
                default:
                begin
                    // Spare codes leave everything alone
                end
            endcase
            r.current_id = booted ? slot_id[cur] : '0;
            return r;
        endfunction

        // Note an accepted input transfer and queue its reply
        function void accept_request(request_t rq);
            res_t r;
            r = advance_table(rq);
            op_count[rq.opcode]++;
            status_count[r.status]++;
            if (r.release_valid)
                releases++;
            awaited_replies.push_back(r);
        endfunction

        function void report(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] seen);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on reply %0d, %s: expected %h, got %h",
                         replies_checked, what, want, seen);
        endfunction

        function void check_field(string what, logic [DATA_W-1:0] want,
                                  logic [DATA_W-1:0] seen);
            if (want !== seen)
                report(what, want, seen);
        endfunction

        // Compare an accepted output transfer with the oldest awaited reply
        function void compare_reply(res_t got);
            res_t want;
            if (awaited_replies.size() == 0)
            begin
                report("reply with no request outstanding, current_id", '0,
                       DATA_W'(got.current_id));
                return;
            end
            want = awaited_replies.pop_front();
            replies_checked++;
            check_field("status", DATA_W'(want.status), DATA_W'(got.status));
            check_field("next_stack_pointer", want.next_stack_pointer, got.next_stack_pointer);
            check_field("next_root",          want.next_root,          got.next_root);
            check_field("next_kernel_stack",  want.next_kernel_stack,  got.next_kernel_stack);
            check_field("tls_base",           want.tls_base,           got.tls_base);
            check_field("tls_write", DATA_W'(want.tls_write), DATA_W'(got.tls_write));
            check_field("assigned_id", DATA_W'(want.assigned_id), DATA_W'(got.assigned_id));
            check_field("current_id", DATA_W'(want.current_id), DATA_W'(got.current_id));
            check_field("release_valid", DATA_W'(want.release_valid),
                        DATA_W'(got.release_valid));
            check_field("release_root",       want.release_root,       got.release_root);
        endfunction

    endclass

endpackage

[tb/tb_round_robin_task_table_unit.sv]
// Testbench top for round_robin_task_table_unit: drives requests in random bursts,
// stalls replies, and checks each reply. Depends on rrtt_pkg and task_table_check_pkg.
module tb_round_robin_task_table_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import rrtt_pkg::*;
    import task_table_check_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 215;
    localparam int SETTLE_TICKS = SLOTS + 8;

    logic              clk              = 1'b0;
    logic              rst_n            = 1'b0;
    logic              cfg_we           = 1'b0;
    logic [DATA_W-1:0] cfg_wdata        = '0;
    logic              in_valid         = 1'b0;
    logic              in_ready;
    logic [OP_W-1:0]   opcode           = '0;
    logic [DATA_W-1:0] stack_pointer    = '0;
    logic [DATA_W-1:0] address_root     = '0;
    logic [DATA_W-1:0] kernel_stack_top = '0;
    logic [ID_W-1:0]   target_id        = '0;
    logic              out_valid;
    logic              out_ready        = 1'b0;
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] next_stack_pointer;
    logic [DATA_W-1:0] next_root;
    logic [DATA_W-1:0] next_kernel_stack;
    logic [DATA_W-1:0] tls_base;
    logic              tls_write;
    logic [ID_W-1:0]   assigned_id;
    logic [ID_W-1:0]   current_id;
    logic              release_valid;
    logic [DATA_W-1:0] release_root;

    task_table_scoreboard sb = new();

    int burst_left  = 0;
    int stall_left  = 0;
    int stall_mode  = 0;
    int rx_cycles   = 0;
    int cycle_count = 0;

    round_robin_task_table_unit #(
        .MAX_TASKS(SLOTS)
    ) uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .opcode            (opcode),
        .stack_pointer     (stack_pointer),
        .address_root      (address_root),
        .kernel_stack_top  (kernel_stack_top),
        .target_id         (target_id),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .next_stack_pointer(next_stack_pointer),
        .next_root         (next_root),
        .next_kernel_stack (next_kernel_stack),
        .tls_base          (tls_base),
        .tls_write         (tls_write),
        .assigned_id       (assigned_id),
        .current_id        (current_id),
        .release_valid     (release_valid),
        .release_root      (release_root)
    );

    always #10 clk = ~clk;

    function automatic logic [DATA_W-1:0] wide_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic request_t make_req(logic [OP_W-1:0] op, logic [DATA_W-1:0] sp,
                                          logic [DATA_W-1:0] root, logic [DATA_W-1:0] ks,
                                          logic [ID_W-1:0] tgt);
        request_t rq;
        rq.opcode           = op;
        rq.stack_pointer    = sp;
        rq.address_root     = root;
        rq.kernel_stack_top = ks;
        rq.target_id        = tgt;
        return rq;
    endfunction

    // Random request, weighted toward scheduling on a live table
    function automatic request_t pick_request();
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] root;
        logic [ID_W-1:0]   tgt;
        int                r;
        r = $urandom_range(0, 99);
        if (r < 3)
            op = OP_INIT;
        else if (r < 23)
            op = OP_CREATE;
        else if (r < 63)
            op = OP_SCHEDULE;
        else if (r < 77)
            op = OP_TERMINATE;
        else if (r < 89)
            op = OP_KILL_CUR;
        else if (r < 95)
            op = OP_KILL_ALL;
        else
            op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
        case ($urandom_range(0, 7))
            0, 1:    root = '0;
            2:       root = sb.kroot;
            default: root = wide_value();
        endcase
        case ($urandom_range(0, 9))
            0:       tgt = '0;
            1:       tgt = '1;
            2:       tgt = ID_W'($urandom);
            3:       tgt = KERNEL_TASK_ID;
            default: tgt = ID_W'($urandom_range(2, 18));
        endcase
        return make_req(op, wide_value(), root, wide_value(), tgt);
    endfunction

    // Present one request, hold it until the transfer, then pace the next one
    task automatic issue(request_t rq);
        opcode           <= rq.opcode;
        stack_pointer    <= rq.stack_pointer;
        address_root     <= rq.address_root;
        kernel_stack_top <= rq.kernel_stack_top;
        target_id        <= rq.target_id;
        in_valid         <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.accept_request(rq);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 7);
        end
    endtask

    // Drop valid, wait for every reply, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Reply side: check each output transfer, stall on a pattern of its own
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.compare_reply({status, next_stack_pointer, next_root, next_kernel_stack,
                              tls_base, tls_write, assigned_id, current_id,
                              release_valid, release_root});
        rx_cycles++;
        if (rx_cycles % 256 == 0)
            stall_mode = $urandom_range(0, 2);
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (stall_mode == 1 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 4);
            else if (stall_mode == 2 && $urandom_range(0, 2) == 0)
                stall_left = $urandom_range(1, 15);
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d replies outstanding",
                 cycle_count, sb.pending());
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        logic [DATA_W-1:0] root_setting [PHASES];
        int                k;
        root_setting[0] = '0;
        root_setting[1] = '1;
        root_setting[2] = {$urandom, $urandom};
        root_setting[3] = '0;
        root_setting[4] = TLS_VIRT_BASE;

        // Hold reset, release it once
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Before init every real operation must be turned away; the spare codes are no-ops
        issue(make_req(OP_CREATE, 64'h1000, 64'h2000, 64'h3000, '0));
        issue(make_req(OP_SCHEDULE, '1, '0, '0, '0));
        issue(make_req(OP_TERMINATE, '0, '0, '0, KERNEL_TASK_ID));
        issue(make_req(OP_TERMINATE, '0, '0, '0, '1));
        issue(make_req(OP_KILL_CUR, '1, '1, '1, '1));
        issue(make_req(OP_KILL_ALL, '0, '0, '0, '0));
        issue(make_req(OP_SPARE6, '1, '1, '1, '1));
        issue(make_req(OP_SPARE7, '0, '0, '0, '0));

        // Boot, fill the table, then overflow it
        issue(make_req(OP_INIT, '0, '0, '1, '0));
        for (k = 0; k < SLOTS - 1; k++)
            issue(make_req(OP_CREATE, {$urandom, $urandom},
                           (k % 3 == 0) ? '0 : (k % 3 == 1) ? '1 : {$urandom, $urandom},
                           {$urandom, $urandom}, '0));
        issue(make_req(OP_CREATE, '1, '1, '1, '0));
        issue(make_req(OP_SCHEDULE, '0, '0, '0, '0));

        // Random traffic under each kernel-root setting
        for (k = 0; k < PHASES; k++)
        begin
            if (k > 0)
            begin
                drain();
                cfg_wdata <= root_setting[k];
                cfg_we    <= 1'b1;
                @(posedge clk);
                cfg_we    <= 1'b0;
                sb.set_kernel_root(root_setting[k]);
            end
            repeat (PHASE_ITEMS) issue(pick_request());
        end
        drain();

        $write("Sent %0d init, %0d create, %0d schedule, %0d terminate, ",
               sb.op_count[OP_INIT], sb.op_count[OP_CREATE], sb.op_count[OP_SCHEDULE],
               sb.op_count[OP_TERMINATE]);
        $display("%0d kill-current, %0d kill-all, %0d spare-code requests",
                 sb.op_count[OP_KILL_CUR], sb.op_count[OP_KILL_ALL],
                 sb.op_count[OP_SPARE6] + sb.op_count[OP_SPARE7]);
        $write("Checked %0d replies under %0d kernel roots: %0d refused, ",
               sb.replies_checked, PHASES, sb.status_count[STAT_REFUSED]);
        $display("%0d not found, %0d full, %0d before init, %0d releases",
                 sb.status_count[STAT_NOTFOUND], sb.status_count[STAT_FULL],
                 sb.status_count[STAT_NOINIT], sb.releases);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
        begin
            $display("%0d mismatches, %0d replies never arrived", sb.mismatches, sb.pending());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
